// ===== rtl/cvls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvls_pkg: shared types and constants for the cell velocity solver
// Holds Q-format constants, saturation helpers and divider req/rsp structs.
// ----------------------------------------------------------------------------
package cvls_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned MaxDims  = 3;

  localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64Min = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32Min = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic              start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return S64Max;
    if (a[63] && b[63] && !s[63]) return S64Min;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (!a[63] && b[63] && s[63]) return S64Max;
    if (a[63] && !b[63] && !s[63]) return S64Min;
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32Max) return 32'sh7FFF_FFFF;
    if (v < S32Min) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/cvls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvls_div: signed 64-bit restoring divider
// One quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cvls_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cvls_pkg::div_req_t req_i,
  output cvls_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q[63:0], quo_q[63]};
    trial   = shifted - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      rem_d  = '0;
      quo_d  = req_i.num[63] ? 64'(-req_i.num) : req_i.num;
      den_d  = req_i.den[63] ? 64'(-req_i.den) : req_i.den;
      neg_d  = req_i.num[63] ^ req_i.den[63];
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) quo_d = 64'(-quo_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ===== rtl/cell_velocity_least_squares_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_velocity_least_squares_top: least-squares cell velocity from faces
// Accumulates normal products per face and solves by Cholesky on last face.
// ----------------------------------------------------------------------------
// Usage: face requests arrive on the s_axis channel, one face per request.
// tdata packs normal_x, normal_y, normal_z, face_flux, molar_density (bits
// 0..158, padded to 160); tlast marks the last face of a cell. Each face is
// accepted, then nine products (six for the normal matrix, three flux
// moments) run on the one shared 32x32 multiplier before the next face is
// taken. A face without tlast yields no result. On the last face the block
// runs the Cholesky solve, forward and back substitution and density
// scaling; square roots run on a serial unit and every divide on the
// shared serial divider. The velocity request then waits in the output
// register on m_axis (tdata: velocity_x, y, z; tuser: solve_status) while
// the next cell's faces may already be accepted. If the receiver stalls
// with a result still held, the next last face waits before its solve.
// Reset clears the accumulators and sets space_dims to 3; the APB register
// 0 at address 0 selects 2 or 3 dims.
// ----------------------------------------------------------------------------
module cell_velocity_least_squares_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // normal_x[31:0], normal_y[63:32], normal_z[95:64], face_flux[127:96],
  // molar_density[158:128], zero pad
  input  logic [159:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // velocity_x[31:0], velocity_y[63:32], velocity_z[95:64]
  output logic [95:0]  m_axis_tdata_o,
  // solve_status[0]
  output logic         m_axis_tuser_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [2:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_WAIT_OUT, ST_SOLVE_J, ST_DIAG_SUB, ST_SQRT,
    ST_OFF_INIT, ST_OFF_SUB, ST_OFF_DIV, ST_FW_INIT, ST_FW_SUB, ST_FW_DIV,
    ST_BK_INIT, ST_BK_SUB, ST_BK_DIV, ST_VEL_DIV, ST_DIV_WAIT, ST_EMIT
  } state_e;

  state_e state_q, ret_q;
  logic [1:0] dims_q;
  logic       three_d;
  assign three_d  = (dims_q == 2'd3);
  assign pready_o = 1'b1;
  assign prdata_o = {30'd0, dims_q};

  logic signed [63:0] a_q [6];
  logic signed [63:0] b_q [3];
  logic signed [31:0] l_q [3][3];
  logic signed [31:0] y_q [3];
  logic signed [31:0] x_q [3];
  logic signed [31:0] v_q [3];
  logic signed [31:0] n_q [3];
  logic signed [31:0] flux_q;
  logic [30:0]        rho_q;
  logic               last_q;
  logic [2:0]         step_q;
  logic [1:0]         i_q, j_q, k_q;
  logic signed [63:0] t_q;
  logic               fail_q;
  logic               out_valid_q;
  logic               pending_q;

  // Shared multiplier operands.
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  assign prod = 64'(ma) * 64'(mb);

  // Square root unit state (serial shift-and-subtract).
  logic [63:0] sq_v_q, sq_res_q, sq_bit_q;

  cvls_pkg::div_req_t dreq;
  cvls_pkg::div_rsp_t drsp;
  cvls_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  function automatic logic [2:0] pidx(input logic [1:0] r, input logic [1:0] c);
    logic [1:0] lo, hi;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    if (lo == 2'd0) return {1'b0, hi};
    if (lo == 2'd1) return 3'd2 + {1'b0, hi};
    return 3'd5;
  endfunction

  logic [1:0] dmax;
  assign dmax = three_d ? 2'd2 : 2'd1;

  always_comb begin
    ma = n_q[0];
    mb = n_q[0];
    unique case (state_q)
      ST_MUL: begin
        unique case (step_q)
          3'd0: begin ma = n_q[0]; mb = n_q[0]; end
          3'd1: begin ma = n_q[0]; mb = n_q[1]; end
          3'd2: begin ma = n_q[0]; mb = n_q[2]; end
          3'd3: begin ma = n_q[1]; mb = n_q[1]; end
          3'd4: begin ma = n_q[1]; mb = n_q[2]; end
          3'd5: begin ma = n_q[2]; mb = n_q[2]; end
          3'd6: begin ma = n_q[0]; mb = flux_q; end
          default: begin ma = n_q[1]; mb = flux_q; end
        endcase
      end
      ST_DIAG_SUB: begin ma = l_q[j_q][k_q]; mb = l_q[j_q][k_q]; end
      ST_OFF_SUB:  begin ma = l_q[i_q][k_q]; mb = l_q[j_q][k_q]; end
      ST_FW_SUB:   begin ma = l_q[i_q][k_q]; mb = y_q[k_q]; end
      ST_BK_SUB:   begin ma = l_q[k_q][i_q]; mb = x_q[k_q]; end
      default: begin
        if (state_q == ST_ACC) begin ma = n_q[2]; mb = flux_q; end
      end
    endcase
  end

  logic cfg_wr;
  assign cfg_wr = psel_i && penable_i && pwrite_i && (paddr_i[2] == 1'b0);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {v_q[2], v_q[1], v_q[0]};
  assign m_axis_tuser_o  = fail_q;

  logic [63:0] sq_tr;
  assign sq_tr = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      dims_q      <= 2'd3;
      out_valid_q <= 1'b0;
      pending_q   <= 1'b0;
      dreq        <= '0;
      step_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      fail_q      <= 1'b0;
      for (int e = 0; e < 6; e++) a_q[e] <= '0;
      for (int e = 0; e < 3; e++) b_q[e] <= '0;
    end else begin
      if (cfg_wr) dims_q <= pwdata_i[1:0];
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            n_q[0] <= s_axis_tdata_i[31:0];
            n_q[1] <= s_axis_tdata_i[63:32];
            n_q[2] <= three_d ? s_axis_tdata_i[95:64] : 32'sd0;
            flux_q <= s_axis_tdata_i[127:96];
            rho_q  <= (s_axis_tdata_i[158:128] == 31'd0) ? 31'd1
                                                          : s_axis_tdata_i[158:128];
            last_q <= s_axis_tlast_i;
            step_q <= 3'd0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (step_q < 3'd6) begin
            a_q[step_q] <= cvls_pkg::sat_add(a_q[step_q], prod);
          end else begin
            b_q[step_q[0]] <= cvls_pkg::sat_add(b_q[step_q[0]], prod);
          end
          if (step_q == 3'd7) state_q <= ST_ACC;
          step_q <= step_q + 3'd1;
        end
        ST_ACC: begin
          b_q[2]  <= cvls_pkg::sat_add(b_q[2], prod);
          state_q <= last_q ? ST_WAIT_OUT : ST_IDLE;
        end
        ST_WAIT_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            for (int r = 0; r < 3; r++) begin
              y_q[r] <= '0; x_q[r] <= '0; v_q[r] <= '0;
              for (int c = 0; c < 3; c++) l_q[r][c] <= '0;
            end
            fail_q  <= 1'b0;
            j_q     <= 2'd0;
            state_q <= ST_SOLVE_J;
          end
        end
        ST_SOLVE_J: begin
          t_q     <= a_q[pidx(j_q, j_q)];
          k_q     <= 2'd0;
          state_q <= ST_DIAG_SUB;
        end
        ST_DIAG_SUB: begin
          if (k_q < j_q) begin
            t_q <= cvls_pkg::sat_sub(t_q, prod);
            k_q <= k_q + 2'd1;
          end else if (t_q <= 64'sd0) begin
            fail_q  <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            sq_v_q   <= t_q;
            sq_res_q <= '0;
            sq_bit_q <= 64'h4000_0000_0000_0000;
            state_q  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_bit_q == 64'd0) begin
            if (sq_res_q == 64'd0) begin
              fail_q  <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              l_q[j_q][j_q] <= (sq_res_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                           : sq_res_q[31:0];
              i_q     <= j_q + 2'd1;
              state_q <= ST_OFF_INIT;
            end
          end else begin
            if (sq_v_q >= sq_tr) begin
              sq_v_q   <= sq_v_q - sq_tr;
              sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
            end else begin
              sq_res_q <= sq_res_q >> 1;
            end
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        ST_OFF_INIT: begin
          if (i_q > dmax || i_q == 2'd3) begin
            if (j_q == dmax) begin
              i_q <= 2'd0;
              state_q <= ST_FW_INIT;
            end else begin
              j_q <= j_q + 2'd1;
              state_q <= ST_SOLVE_J;
            end
          end else begin
            t_q     <= a_q[pidx(i_q, j_q)];
            k_q     <= 2'd0;
            state_q <= ST_OFF_SUB;
          end
        end
        ST_OFF_SUB: begin
          if (k_q < j_q) begin
            t_q <= cvls_pkg::sat_sub(t_q, prod);
            k_q <= k_q + 2'd1;
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= t_q;
            dreq.den   <= 64'(l_q[j_q][j_q]);
            ret_q      <= ST_OFF_DIV;
            state_q    <= ST_DIV_WAIT;
          end
        end
        ST_OFF_DIV: begin
          l_q[i_q][j_q] <= cvls_pkg::sat32(drsp.quo);
          i_q     <= i_q + 2'd1;
          state_q <= ST_OFF_INIT;
        end
        ST_FW_INIT: begin
          if (i_q > dmax) begin
            i_q     <= dmax;
            state_q <= ST_BK_INIT;
          end else begin
            t_q     <= b_q[i_q];
            k_q     <= 2'd0;
            state_q <= ST_FW_SUB;
          end
        end
        ST_FW_SUB: begin
          if (k_q < i_q) begin
            t_q <= cvls_pkg::sat_sub(t_q, prod);
            k_q <= k_q + 2'd1;
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= t_q;
            dreq.den   <= 64'(l_q[i_q][i_q]);
            ret_q      <= ST_FW_DIV;
            state_q    <= ST_DIV_WAIT;
          end
        end
        ST_FW_DIV: begin
          y_q[i_q] <= cvls_pkg::sat32(drsp.quo);
          i_q      <= i_q + 2'd1;
          state_q  <= ST_FW_INIT;
        end
        ST_BK_INIT: begin
          t_q     <= 64'(y_q[i_q]) <<< cvls_pkg::FracBits;
          k_q     <= i_q + 2'd1;
          state_q <= ST_BK_SUB;
        end
        ST_BK_SUB: begin
          if (k_q <= dmax && k_q != 2'd3) begin
            t_q <= cvls_pkg::sat_sub(t_q, prod);
            k_q <= k_q + 2'd1;
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= t_q;
            dreq.den   <= 64'(l_q[i_q][i_q]);
            ret_q      <= ST_BK_DIV;
            state_q    <= ST_DIV_WAIT;
          end
        end
        ST_BK_DIV: begin
          x_q[i_q] <= cvls_pkg::sat32(drsp.quo);
          if (i_q == 2'd0) begin
            state_q <= ST_VEL_DIV;
          end else begin
            i_q     <= i_q - 2'd1;
            state_q <= ST_BK_INIT;
          end
        end
        ST_VEL_DIV: begin
          // pending_q says a density divide for component i_q has finished.
          if (pending_q) v_q[i_q] <= cvls_pkg::sat32(drsp.quo);
          if (pending_q && i_q == dmax) begin
            pending_q <= 1'b0;
            state_q   <= ST_EMIT;
          end else begin
            dreq.start <= 1'b1;
            dreq.num   <= 64'(x_q[pending_q ? i_q + 2'd1 : i_q]) <<< cvls_pkg::FracBits;
            dreq.den   <= {33'd0, rho_q};
            if (pending_q) i_q <= i_q + 2'd1;
            pending_q  <= 1'b1;
            ret_q      <= ST_VEL_DIV;
            state_q    <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          dreq.start <= 1'b0;
          if (drsp.done) state_q <= ret_q;
        end
        ST_EMIT: begin
          if (fail_q) begin
            for (int r = 0; r < 3; r++) v_q[r] <= '0;
          end
          out_valid_q <= 1'b1;
          for (int e = 0; e < 6; e++) a_q[e] <= '0;
          for (int e = 0; e < 3; e++) b_q[e] <= '0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/cell_velocity_least_squares_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_velocity_least_squares_top_test: self-checking bench for the solver
// Drives cells of faces on the input stream, predicts each velocity request
// with an independent Q16.16 Cholesky solve or a typed-in one; compares all.
// ----------------------------------------------------------------------------
module cell_velocity_least_squares_top_test;

  localparam int  ONE   = 65536;
  localparam int  LIMIT = 3000000;
  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic [30:0] RMAX = 31'h7FFF_FFFF;
  localparam logic [2:0] ADDR_SPACE_DIMS = 3'd0;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic               status;
  } velocity_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] fl;
    logic [30:0]        rho;
    logic               last;
    logic               typed;
    velocity_t          vel;
  } face_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i = '0;
  logic         s_axis_tlast_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [2:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  // Tag that travels with each face so the monitor knows a typed-in answer.
  logic         tag_typed = 1'b0;
  velocity_t    tag_vel = '0;

  longint       normal_sums [6];
  longint       flux_sums [3];
  logic [1:0]   dims_reg;
  velocity_t    velocity_q [$];
  int           errors = 0;
  int           results = 0;
  int           faces = 0;
  int           failed_solves = 0;
  int           cycles = 0;
  int           snd_idle = 0;
  int           rcv_idle = 0;
  logic         holding = 1'b0;

  cell_velocity_least_squares_top dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint clamp64(input logic signed [64:0] v);
    if (v[64] != v[63]) return v[64] ? cvls_pkg::S64Min : cvls_pkg::S64Max;
    return v[63:0];
  endfunction

  function automatic longint add64(input longint a, input longint b);
    return clamp64(65'(signed'(a)) + 65'(signed'(b)));
  endfunction

  function automatic longint sub64(input longint a, input longint b);
    return clamp64(65'(signed'(a)) - 65'(signed'(b)));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(QMAX)) return longint'(QMAX);
    if (v < longint'(QMIN)) return longint'(QMIN);
    return v;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Accumulates one face; on the last face solves the normal equations.
  function automatic bit solve_face(input face_t f, output velocity_t vel);
    int     pidx [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
    longint n [3];
    longint lf [3][3];
    longint y [3];
    longint x [3];
    longint v [3];
    longint s, t, rho, flux;
    longint unsigned r;
    int     d, i, j, k;
    bit     fail;
    d = (dims_reg == 2'd3) ? 3 : 2;
    n[0] = f.nx;
    n[1] = f.ny;
    n[2] = (d == 3) ? longint'(f.nz) : 0;
    flux = f.fl;
    rho = (f.rho == 0) ? 1 : longint'(f.rho);
    for (i = 0; i < 3; i++) begin
      flux_sums[i] = add64(flux_sums[i], n[i] * flux);
      for (j = i; j < 3; j++)
        normal_sums[pidx[i][j]] = add64(normal_sums[pidx[i][j]], n[i] * n[j]);
    end
    vel = '0;
    if (!f.last) return 1'b0;
    fail = 1'b0;
    for (i = 0; i < 3; i++) begin
      y[i] = 0; x[i] = 0; v[i] = 0;
      for (j = 0; j < 3; j++) lf[i][j] = 0;
    end
    for (j = 0; j < d; j++) begin
      if (!fail) begin
        s = normal_sums[pidx[j][j]];
        for (k = 0; k < j; k++) s = sub64(s, lf[j][k] * lf[j][k]);
        if (s <= 0) begin
          fail = 1'b1;
        end else begin
          r = floor_sqrt(s);
          if (r > longint'(QMAX)) r = longint'(QMAX);
          if (r == 0) fail = 1'b1;
          lf[j][j] = r;
          for (i = j + 1; i < d; i++) begin
            t = normal_sums[pidx[i][j]];
            for (k = 0; k < j; k++) t = sub64(t, lf[i][k] * lf[j][k]);
            if (!fail) lf[i][j] = clamp32(t / lf[j][j]);
          end
        end
      end
    end
    if (!fail) begin
      for (i = 0; i < d; i++) begin
        t = flux_sums[i];
        for (k = 0; k < i; k++) t = sub64(t, lf[i][k] * y[k]);
        y[i] = clamp32(t / lf[i][i]);
      end
      for (i = d - 1; i >= 0; i--) begin
        t = y[i] * ONE;
        for (k = i + 1; k < d; k++) t = sub64(t, lf[k][i] * x[k]);
        x[i] = clamp32(t / lf[i][i]);
      end
      for (i = 0; i < d; i++) v[i] = clamp32((x[i] * ONE) / rho);
      vel.vx = v[0][31:0];
      vel.vy = v[1][31:0];
      vel.vz = v[2][31:0];
    end
    vel.status = fail;
    for (i = 0; i < 3; i++) flux_sums[i] = 0;
    for (i = 0; i < 6; i++) normal_sums[i] = 0;
    return 1'b1;
  endfunction

  // Request monitor: both handshakes are sampled with pre-edge values.
  always @(posedge clk_i) begin
    face_t     f;
    velocity_t want;
    velocity_t got;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      f = '0;
      {f.rho, f.fl, f.nz, f.ny, f.nx} = s_axis_tdata_i[158:0];
      f.last = s_axis_tlast_i;
      faces <= faces + 1;
      if (solve_face(f, want)) velocity_q.push_back(tag_typed ? tag_vel : want);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tdata_o[95:64],
             m_axis_tuser_o};
      results <= results + 1;
      if (got.status) failed_solves <= failed_solves + 1;
      if (velocity_q.size() == 0) begin
        $display("%t: unexpected velocity %h", $realtime, got);
        errors <= errors + 1;
      end else begin
        want = velocity_q.pop_front();
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
            got.status !== want.status) begin
          $display("%t: velocity mismatch expected x=%h y=%h z=%h st=%b",
                   $realtime, want.vx, want.vy, want.vz, want.status);
          $display("%t:                    actual   x=%h y=%h z=%h st=%b",
                   $realtime, got.vx, got.vy, got.vz, got.status);
          errors <= errors + 1;
        end
      end
    end
  end

  // Receiver: random back-pressure, or a long hold while holding is set.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !holding && ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel_i <= 1'b1; pwrite_i <= 1'b1; penable_i <= 1'b0;
    paddr_i <= addr; pwdata_i <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0; penable_i <= 1'b0; pwrite_i <= 1'b0;
    dims_reg = data[1:0];
  endtask

  task automatic drive_face(input face_t f);
    s_axis_tdata_i <= {1'b0, f.rho, f.fl, f.nz, f.ny, f.nx};
    s_axis_tlast_i <= f.last;
    s_axis_tvalid_i <= 1'b1;
    tag_typed <= f.typed;
    tag_vel <= f.vel;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (velocity_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_q();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return $urandom;
    if (sel == 1) return 0;
    if (sel == 2) return $urandom_range(1) ? QMAX : QMIN;
    return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
  endfunction

  function automatic logic [30:0] rand_rho();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 31'($urandom);
    if (sel == 1) return 0;
    if (sel == 2) return RMAX;
    return 31'($urandom_range(ONE / 4, 8 * ONE));
  endfunction

  face_t dir_tab [13] = '{
    '{0, 0, 0, 0, ONE, 1, 1, '{0, 0, 0, 1}},
    '{ONE, 0, 0, ONE, ONE, 1, 1, '{0, 0, 0, 1}},
    '{ONE, 0, 0, 3 * ONE, ONE, 0, 0, '0},
    '{0, ONE, 0, -2 * ONE, ONE, 0, 0, '0},
    '{0, 0, ONE, ONE / 2, ONE, 1, 1, '{3 * ONE, -2 * ONE, ONE / 2, 0}},
    '{ONE, ONE, ONE, ONE, ONE, 1, 0, '0},
    '{QMIN, QMAX, QMIN, QMAX, RMAX, 0, 0, '0},
    '{QMIN, QMIN, QMAX, QMIN, 1, 0, 0, '0},
    '{QMAX, QMIN, QMIN, QMIN, 0, 1, 0, '0},
    '{2 * ONE, ONE, 0, 5 * ONE, ONE, 0, 0, '0},
    '{ONE, 3 * ONE, ONE, -ONE, ONE, 0, 0, '0},
    '{0, ONE, 2 * ONE, ONE, 0, 1, 0, '0},
    '{-1, 1, -1, QMIN, RMAX, 1, 0, '0}
  };

  initial begin
    int    dims_set [4] = '{3, 2, 1, 0};
    int    snd_set [4] = '{8, 49, 0, 0};
    int    rcv_set [4] = '{49, 8, 0, 0};
    int    p, sent, nfaces, k;
    face_t f;
    for (k = 0; k < 6; k++) normal_sums[k] = 0;
    for (k = 0; k < 3; k++) flux_sums[k] = 0;
    dims_reg = 2'd3;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) drive_face(dir_tab[i]);
    drain();

    for (p = 0; p < 4; p++) begin
      apb_write(ADDR_SPACE_DIMS, dims_set[p]);
      snd_idle = snd_set[p];
      rcv_idle = rcv_set[p];
      if (p == 2) begin
        fork
          begin
            holding <= 1'b1;
            repeat (4000) @(posedge clk_i);
            holding <= 1'b0;
          end
        join_none
      end
      sent = 0;
      while (sent < 120) begin
        nfaces = $urandom_range(1, 6);
        for (k = 0; k < nfaces; k++) begin
          f.nx = rand_q(); f.ny = rand_q(); f.nz = rand_q(); f.fl = rand_q();
          f.rho = rand_rho();
          f.last = (k == nfaces - 1);
          f.typed = 1'b0;
          f.vel = '0;
          drive_face(f);
          sent++;
        end
      end
      drain();
    end
    apb_write(ADDR_SPACE_DIMS, 3);

    $display("Accepted %0d faces and checked %0d velocity results (%0d not solvable)",
             faces, results, failed_solves);
    $display("Covered 2D and 3D solves, saturating extremes and long output stalls");
    if (errors == 0 && velocity_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cvls_pkg.sv
rtl/cvls_div.sv
rtl/cell_velocity_least_squares_top.sv
bench/cell_velocity_least_squares_top_test.sv
